// ----- src/ssc_pkg.sv -----
package ssc_pkg;

   // pixel and window
   localparam int PIXEL_W = 8;
   localparam logic [PIXEL_W-1:0] BG_PIXEL = 8'd255;
   localparam logic [PIXEL_W-1:0] DARK_LIMIT = 8'd80;

   typedef logic [PIXEL_W-1:0] pixel_type;
   // [row top..bottom][column left..right]
   typedef logic [2:0][2:0][PIXEL_W-1:0] win_type;

   localparam win_type WIN_BG = {9{BG_PIXEL}};

   // shade codes
   localparam int SHADE_W = 2;
   localparam logic [SHADE_W-1:0] SHADE_BG    = 2'd0;
   localparam logic [SHADE_W-1:0] SHADE_FULL  = 2'd1;
   localparam logic [SHADE_W-1:0] SHADE_DARK  = 2'd2;
   localparam logic [SHADE_W-1:0] SHADE_LIGHT = 2'd3;

   typedef struct packed {
      pixel_type             value;
      logic [SHADE_W-1:0]    shade;
   } res_type;

   // control registers
   localparam int CSR_IDX_W = 2;
   localparam int LINE_WIDTH_W = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH_EN  = 2'd1;
   localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 10'd400;
   localparam int MIN_WIDTH = 3;

   // rows seen counter
   localparam logic [1:0] ROWS_ONE = 2'd1;
   localparam logic [1:0] ROWS_TWO = 2'd2;

endpackage

// ----- src/selective_3x3_smoothing_classifier_unit.sv -----
// path: the item that completes a pixel's window is registered in stage 1, then in stage 2,
//   and its result then loads the output register (that item is line_width+1 items later)
// throughput: 1 item per cycle while rsp_ready keeps the output free; a stalled output holds
//   the stages, and each line store takes one read and one write per cycle
// reset: synchronous, clears pipeline valids, column, row count, window and sticky flag;
//   line stores are not cleared and hold no data until rows are written
module selective_3x3_smoothing_classifier_unit #(
   parameter int MAX_WIDTH = 512
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ssc_pkg::PIXEL_W-1:0]        req_pixel,
   input  logic                               req_first_of_frame,
   input  logic                               req_flush,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ssc_pkg::PIXEL_W-1:0]        rsp_value,
   output logic [ssc_pkg::SHADE_W-1:0]        rsp_shade,
   output logic                               rsp_partial_seen,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ssc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ssc_pkg::LINE_WIDTH_W-1:0]   csr_data
);
   import ssc_pkg::*;

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CMPW = (WW > LINE_WIDTH_W) ? WW : LINE_WIDTH_W;

   // control registers
   logic [LINE_WIDTH_W-1:0] line_width_ff;
   logic                    smooth_en_ff;

   // column and row tracking
   logic [AW-1:0] col_ff, col_in, col_cur;
   logic [1:0]    rows_ff, rows_in, rows_cur;
   logic [WW-1:0] w_eff, col_next_ext;
   logic [CMPW-1:0] lw_ext;

   // line stores and their registered read data
   pixel_type upper_mem [MAX_WIDTH];
   pixel_type middle_mem [MAX_WIDTH];
   pixel_type rd_up_ff, rd_mid_ff;

   // stage 1: accepted item
   logic          s1_valid_ff;
   pixel_type     s1_px_ff;
   logic [AW-1:0] s1_col_ff;
   logic [1:0]    s1_rows_ff;
   logic          s1_first_ff;

   // stage 2: window seen by the emitted result
   logic          s2_valid_ff;
   logic          s2_emit_ff;
   logic          s2_first_ff;
   win_type       s2_win_ff;

   // window state
   win_type   win_ff, win_in, win_base, emit_win;
   logic      emit;
   pixel_type top, mid, px_in;

   // output register and sticky flag
   logic      rsp_valid_ff, rsp_valid_in;
   pixel_type rsp_value_ff;
   logic [SHADE_W-1:0] rsp_shade_ff;
   logic      rsp_partial_ff;
   logic      partial_ff, partial_in;
   res_type   res;

   // handshake flow
   logic accept, out_free, s2_go, s2_free, s1_go, s1_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_go     = s2_valid_ff && (!s2_emit_ff || out_free);
   assign s2_free   = !s2_valid_ff || s2_go;
   assign s1_go     = s1_valid_ff && s2_free;
   assign s1_free   = !s1_valid_ff || s1_go;
   assign req_ready = s1_free;
   assign accept    = req_valid && s1_free;
   assign csr_ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         smooth_en_ff  <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LINE_WIDTH: line_width_ff <= csr_data;
            CSR_SMOOTH_EN:  smooth_en_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // effective width clamped to the supported range
   always_comb begin
      lw_ext = CMPW'(line_width_ff);
      if (lw_ext < CMPW'(MIN_WIDTH)) begin
         w_eff = WW'(MIN_WIDTH);
      end else if (lw_ext > CMPW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = lw_ext[WW-1:0];
      end
   end

   // column of the incoming item and next column and row count
   always_comb begin
      col_cur  = req_first_of_frame ? '0 : col_ff;
      rows_cur = req_first_of_frame ? '0 : rows_ff;
      if (WW'(col_cur) >= w_eff) begin
         col_cur = '0;
      end
      col_next_ext = WW'(col_cur) + WW'(1);
      col_in  = col_cur + AW'(1);
      rows_in = rows_cur;
      if (col_next_ext >= w_eff) begin
         col_in = '0;
         if (rows_cur != ROWS_TWO) begin
            rows_in = rows_cur + 2'd1;
         end
      end
      px_in = req_flush ? BG_PIXEL : req_pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         rows_ff <= '0;
      end else if (accept) begin
         col_ff  <= col_in;
         rows_ff <= rows_in;
      end
   end

   // stage 1 load and line store reads
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff    <= px_in;
         s1_col_ff   <= col_cur;
         s1_rows_ff  <= rows_cur;
         s1_first_ff <= req_first_of_frame;
         rd_up_ff    <= upper_mem[col_cur];
         rd_mid_ff   <= middle_mem[col_cur];
      end
   end

   // column pixels from the line stores, background above the frame
   assign top = (s1_rows_ff >= ROWS_TWO) ? rd_up_ff : BG_PIXEL;
   assign mid = (s1_rows_ff >= ROWS_ONE) ? rd_mid_ff : BG_PIXEL;

   // line store writes as the item leaves stage 1
   always_ff @(posedge clock) begin
      if (s1_go) begin
         upper_mem[s1_col_ff]  <= mid;
         middle_mem[s1_col_ff] <= s1_px_ff;
      end
   end

   // window update, with the row wrap emitting the right edge first
   always_comb begin
      win_base = s1_first_ff ? WIN_BG : win_ff;
      emit_win = win_base;
      for (int r = 0; r < 3; r++) begin
         emit_win[r][0] = win_base[r][1];
         emit_win[r][1] = win_base[r][2];
      end
      if (s1_col_ff == '0) begin
         for (int r = 0; r < 3; r++) begin
            emit_win[r][2] = BG_PIXEL;
         end
         win_in = WIN_BG;
         win_in[0][2] = top;
         win_in[1][2] = mid;
         win_in[2][2] = s1_px_ff;
         emit = (s1_rows_ff >= ROWS_TWO);
      end else begin
         emit_win[0][2] = top;
         emit_win[1][2] = mid;
         emit_win[2][2] = s1_px_ff;
         win_in = emit_win;
         emit = (s1_rows_ff >= ROWS_ONE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= WIN_BG;
      end else if (s1_go) begin
         win_ff <= win_in;
      end
   end

   // stage 2 load
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s2_emit_ff  <= emit;
         s2_first_ff <= s1_first_ff;
         s2_win_ff   <= emit_win;
      end
   end

   ssc_smooth u_smooth (
      .win       (s2_win_ff),
      .smooth_en (smooth_en_ff),
      .res       (res)
   );

   // sticky flag, cleared at frame start
   always_comb begin
      partial_in = s2_first_ff ? 1'b0 : partial_ff;
      if (s2_emit_ff && res.shade == SHADE_LIGHT) begin
         partial_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= 1'b0;
      end else if (s2_go) begin
         partial_ff <= partial_in;
      end
   end

   // output register
   always_comb begin
      if (s2_go && s2_emit_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go && s2_emit_ff) begin
         rsp_value_ff   <= res.value;
         rsp_shade_ff   <= res.shade;
         rsp_partial_ff <= partial_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_shade        = rsp_shade_ff;
   assign rsp_partial_seen = rsp_partial_ff;

endmodule

// ----- src/ssc_smooth.sv -----
module ssc_smooth (
   input  ssc_pkg::win_type win,
   input  logic             smooth_en,
   output ssc_pkg::res_type res
);
   import ssc_pkg::*;

   logic [PIXEL_W:0] sum;
   pixel_type        center;
   pixel_type        val;

   // center/2 plus each neighbor/16
   always_comb begin
      center = win[1][1];
      sum = {2'b00, center[PIXEL_W-1:1]};
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            if (r != 1 || k != 1) begin
               sum = sum + {5'b00000, win[r][k][PIXEL_W-1:4]};
            end
         end
      end
   end

   // background and bypass pass the center through
   always_comb begin
      if (center == BG_PIXEL || !smooth_en) begin
         val = center;
      end else if (sum[PIXEL_W]) begin
         val = BG_PIXEL;
      end else begin
         val = sum[PIXEL_W-1:0];
      end
   end

   // shade classification
   always_comb begin
      res.value = val;
      if (val == BG_PIXEL) begin
         res.shade = SHADE_BG;
      end else if (val == '0) begin
         res.shade = SHADE_FULL;
      end else if (val < DARK_LIMIT) begin
         res.shade = SHADE_DARK;
      end else begin
         res.shade = SHADE_LIGHT;
      end
   end

endmodule

// ----- src/ssc_checker.sv -----
module ssc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ssc_pkg::PIXEL_W-1:0]   rsp_value,
   input logic [ssc_pkg::SHADE_W-1:0]   rsp_shade,
   input logic                          rsp_partial_seen
);
   import ssc_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_shade))
      else $error("result changed while stalled");

   // background shade exactly for value 255, full shade exactly for value 0
   a_shade_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_shade == SHADE_BG) == (rsp_value == BG_PIXEL)) &&
                    ((rsp_shade == SHADE_FULL) == (rsp_value == '0)))
      else $error("shade does not match value");

   // a light result always shows the sticky flag
   a_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_shade == SHADE_LIGHT |-> rsp_partial_seen)
      else $error("light shade without sticky flag");

   // nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind selective_3x3_smoothing_classifier_unit ssc_checker u_ssc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_value        (rsp_value),
   .rsp_shade        (rsp_shade),
   .rsp_partial_seen (rsp_partial_seen)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import ssc_pkg::*;

   localparam int LINE_MAX = 512;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 500;
   // no register sits at this index, writes to it must leave the block unchanged
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum {PAL_MIXED, PAL_DARK, PAL_BRIGHT} palette_type;

   typedef struct {
      pixel_type          value;
      logic [SHADE_W-1:0] shade;
      logic               partial_seen;
   } smoothed_type;

   // window predictor and store of expected smoothed pixels
   class smoothed_pixel_board;
      logic [LINE_WIDTH_W-1:0] line_width;
      bit                      smoothing_on;
      pixel_type               upper_row [LINE_MAX];
      pixel_type               middle_row [LINE_MAX];
      pixel_type               win [3][3];
      int unsigned             column;
      int unsigned             rows_seen;
      bit                      partial_flag;
      smoothed_type            pending[$];
      int                      failures;

      function new();
         line_width = LINE_WIDTH_RESET;
         smoothing_on = 1'b1;
         foreach (upper_row[i]) begin
            upper_row[i] = '0;
            middle_row[i] = '0;
         end
         fill_background();
         column = 0;
         rows_seen = 0;
         partial_flag = 1'b0;
         failures = 0;
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [LINE_WIDTH_W-1:0] data);
         case (idx)
            CSR_LINE_WIDTH: line_width = data;
            CSR_SMOOTH_EN: smoothing_on = data[0];
            default: ;
         endcase
      endfunction

      function void fill_background();
         foreach (win[r, k]) win[r][k] = BG_PIXEL;
      endfunction

      function void shift_window(input pixel_type top, input pixel_type mid,
                                 input pixel_type bot);
         for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
         end
         win[0][2] = top;
         win[1][2] = mid;
         win[2][2] = bot;
      endfunction

      // smooth and classify the window center, queue it as expected
      function void predict_center();
         int unsigned  c;
         int unsigned  v;
         smoothed_type e;
         c = win[1][1];
         if (c == BG_PIXEL || !smoothing_on) begin
            v = c;
         end else begin
            v = c >> 1;
            for (int r = 0; r < 3; r++)
               for (int k = 0; k < 3; k++)
                  if (r != 1 || k != 1) v += win[r][k] >> 4;
         end
         if (v > 255) v = 255;
         e.value = pixel_type'(v);
         if (e.value == BG_PIXEL) begin
            e.shade = SHADE_BG;
         end else if (e.value == 0) begin
            e.shade = SHADE_FULL;
         end else if (e.value < DARK_LIMIT) begin
            e.shade = SHADE_DARK;
         end else begin
            e.shade = SHADE_LIGHT;
            partial_flag = 1'b1;
         end
         e.partial_seen = partial_flag;
         pending.push_back(e);
      endfunction

      // one accepted input item moves the line stores and the window
      function void accept_pixel(input pixel_type pix, input bit fof, input bit flush);
         int unsigned w;
         int unsigned col;
         pixel_type   px;
         pixel_type   top;
         pixel_type   mid;
         w = line_width;
         if (w < MIN_WIDTH) w = MIN_WIDTH;
         if (w > LINE_MAX) w = LINE_MAX;
         if (fof) begin
            column = 0;
            rows_seen = 0;
            partial_flag = 1'b0;
            fill_background();
         end
         if (column >= w) column = 0;
         col = column;
         px = flush ? BG_PIXEL : pix;
         top = (rows_seen >= 2) ? upper_row[col] : BG_PIXEL;
         mid = (rows_seen >= 1) ? middle_row[col] : BG_PIXEL;
         upper_row[col] = mid;
         middle_row[col] = px;
         if (col == 0) begin
            // right edge of the row two rows up reads background
            if (rows_seen >= 2) begin
               shift_window(BG_PIXEL, BG_PIXEL, BG_PIXEL);
               predict_center();
            end
            fill_background();
            win[0][2] = top;
            win[1][2] = mid;
            win[2][2] = px;
         end else begin
            shift_window(top, mid, px);
            if (rows_seen >= 1) predict_center();
         end
         col++;
         if (col >= w) begin
            col = 0;
            if (rows_seen < 2) rows_seen++;
         end
         column = col;
      endfunction

      function void check_output(input pixel_type value, input logic [SHADE_W-1:0] shade,
                                 input logic partial_seen);
         smoothed_type e;
         if (pending.size() == 0) begin
            $error("unexpected result item: value %0d shade %0d", value, shade);
            failures++;
            return;
         end
         e = pending.pop_front();
         if (value !== e.value) begin
            $error("value: expected %0d, actual %0d", e.value, value);
            failures++;
         end
         if (shade !== e.shade) begin
            $error("shade: expected %0d, actual %0d", e.shade, shade);
            failures++;
         end
         if (partial_seen !== e.partial_seen) begin
            $error("partial_seen: expected %0d, actual %0d", e.partial_seen, partial_seen);
            failures++;
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   pixel_type               req_pixel = '0;
   logic                    req_first_of_frame = 1'b0;
   logic                    req_flush = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   pixel_type               rsp_value;
   logic [SHADE_W-1:0]      rsp_shade;
   logic                    rsp_partial_seen;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [LINE_WIDTH_W-1:0] csr_data = '0;

   smoothed_pixel_board board = new();

   int   items_sent = 0;
   int   burst_left = 0;
   bit   gaps_on = 1'b1;
   int   cur_width = LINE_WIDTH_RESET;
   int   cycle_count = 0;
   logic [7:0] ready_mask = 8'hFF;
   logic [2:0] ready_phase = '0;
   int   ready_hold = 0;

   // directed frames at the narrowest width
   pixel_type dark_grid [9] = '{8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd15, 8'd0, 8'd0, 8'd0};
   pixel_type edge_grid [9] = '{8'd255, 8'd254, 8'd128, 8'd127, 8'd80, 8'd79,
                                8'd16, 8'd255, 8'd1};

   selective_3x3_smoothing_classifier_unit #(
      .MAX_WIDTH(LINE_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pixel(req_pixel),
      .req_first_of_frame(req_first_of_frame),
      .req_flush(req_flush),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_value(rsp_value),
      .rsp_shade(rsp_shade),
      .rsp_partial_seen(rsp_partial_seen),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("selective_3x3_smoothing_classifier_unit test failed");
         $finish;
      end
   end

   // receiver stalls on a rotating mask that changes now and then
   always @(posedge clock) begin
      if (ready_hold == 0) begin
         ready_mask <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
         ready_hold <= $urandom_range(64, 256);
      end else begin
         ready_hold <= ready_hold - 1;
      end
      ready_phase <= ready_phase + 3'd1;
      rsp_ready <= ready_mask[ready_phase];
   end

   // watch all three channels
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.write_reg(csr_index, csr_data);
         if (req_valid && req_ready) board.accept_pixel(req_pixel, req_first_of_frame, req_flush);
         if (rsp_valid && rsp_ready) board.check_output(rsp_value, rsp_shade, rsp_partial_seen);
      end
   end

   function automatic pixel_type pick_pixel(input palette_type palette);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      case (palette)
         PAL_DARK: begin
            if (roll < 60) return pixel_type'($urandom_range(0, 1));
            if (roll < 85) return pixel_type'($urandom_range(2, 15));
            if (roll < 92) return BG_PIXEL;
            return pixel_type'($urandom);
         end
         PAL_BRIGHT: begin
            if (roll < 30) return BG_PIXEL;
            return pixel_type'($urandom_range(160, 254));
         end
         default: begin
            if (roll < 20) return BG_PIXEL;
            if (roll < 30) return '0;
            if (roll < 40) return pixel_type'($urandom_range(1, 15));
            return pixel_type'($urandom);
         end
      endcase
   endfunction

   // one item, held until accepted; bursts end with a gap
   task automatic send_item(input pixel_type pix, input bit fof, input bit flush);
      req_valid <= 1'b1;
      req_pixel <= pix;
      req_first_of_frame <= fof;
      req_flush <= flush;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [LINE_WIDTH_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [LINE_WIDTH_W-1:0] width, input bit smooth);
      write_reg(CSR_LINE_WIDTH, width);
      write_reg(CSR_SMOOTH_EN, {9'($urandom), smooth});
      csr_valid <= 1'b0;
      cur_width = (width < MIN_WIDTH) ? MIN_WIDTH : (width > LINE_MAX) ? LINE_MAX : width;
   endtask

   // stop sending, wait for the last result and for the pipeline to empty
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // a frame of whole rows, some noise items, then padding items
   task automatic send_frame(input int rows, input palette_type palette, input int flushes);
      for (int n = 0; n < rows * cur_width; n++) begin
         if (n > 0 && $urandom_range(0, 49) == 0)
            send_item(pixel_type'($urandom), $urandom_range(0, 3) == 0,
                      $urandom_range(0, 2) == 0);
         send_item(pick_pixel(palette), n == 0, 1'b0);
      end
      for (int n = 0; n < flushes; n++) send_item(pixel_type'($urandom), 1'b0, 1'b1);
   endtask

   initial begin
      int roll;
      int w_reg;
      int flushes;
      int goal;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, stream starts without a frame start
      for (int n = 0; n < 410; n++) send_item(pick_pixel(PAL_MIXED), 1'b0, 1'b0);
      wait_until_idle();

      // width below the minimum acts as the minimum
      write_reg(CSR_UNUSED, 10'h3FF);
      configure(10'd0, 1'b1);
      // all-dark interior gives a full shade
      for (int n = 0; n < 9; n++) send_item(dark_grid[n], n == 0, 1'b0);
      // new frame drops the pending row, then pad past the end of the frame
      for (int n = 0; n < 9; n++) send_item(edge_grid[n], n == 0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hFF, 1'b0, 1'b1);
      for (int n = 0; n < 4; n++) send_item(pixel_type'($urandom), 1'b0, 1'b1);
      send_item(pixel_type'($urandom), 1'b1, 1'b1);
      wait_until_idle();

      // random phases, mostly narrow widths
      goal = items_sent + RANDOM_ITEMS;
      while (items_sent < goal) begin
         roll = $urandom_range(0, 19);
         if (roll == 0) w_reg = $urandom_range(0, 2);
         else if (roll == 1) w_reg = $urandom_range(11, 40);
         else w_reg = $urandom_range(3, 10);
         configure(10'(w_reg), $urandom_range(0, 3) != 0);
         gaps_on = $urandom_range(0, 3) != 0;
         burst_left = 0;
         repeat ($urandom_range(1, 3)) begin
            roll = $urandom_range(0, 9);
            if (roll < 6) flushes = cur_width + 1;
            else if (roll < 8) flushes = $urandom_range(0, cur_width);
            else flushes = cur_width + 1 + $urandom_range(1, cur_width + 2);
            send_frame($urandom_range(1, 5), palette_type'($urandom_range(0, 2)), flushes);
         end
         wait_until_idle();
      end

      // width above the maximum acts as the maximum, one widest row and a short drain
      gaps_on = 1'b1;
      configure(10'h3FF, 1'b1);
      send_frame(1, PAL_MIXED, 40);
      wait_until_idle();

      if (board.failures == 0 && board.pending.size() == 0) begin
         $display("selective_3x3_smoothing_classifier_unit test passed");
      end else begin
         $display("selective_3x3_smoothing_classifier_unit test failed");
      end
      $finish;
   end

endmodule
